// File: sv/rota_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rota_pkg
// Shared types and constants for the RSSI owner arbiter table.
// ----------------------------------------------------------------------------
package rota_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_HI_W = 32;
    localparam int KEY_LO_W = 64;
    localparam int KEY_W    = KEY_HI_W + KEY_LO_W;
    localparam int AVG_W    = 12;
    localparam int HYST_W   = 10;

    localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(30);

    localparam int S_DATA_W = 112;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;

    typedef logic [1:0] owner_t;
    localparam owner_t OWN_NONE = 2'd0;
    localparam owner_t OWN_ANT0 = 2'd1;
    localparam owner_t OWN_ANT1 = 2'd2;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_DECIDE = 1'b1
    } op_t;

    typedef struct packed {
        owner_t                   owner;
        logic [1:0]               seen;
        logic signed [AVG_W-1:0]  avg1;
        logic signed [AVG_W-1:0]  avg0;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   tracked;
        logic   pass;
        owner_t owner;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MISS,
        ST_DATA_RD,
        ST_MODIFY,
        ST_OUT
    } state_t;

endpackage

// File: sv/rota_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rota_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rota_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/rota_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rota_calc
// Entry modify logic: running average update and owner decision.
// ----------------------------------------------------------------------------
module rota_calc (
    input  rota_pkg::op_t                          op,
    input  logic                                   ant,
    input  logic signed [rota_pkg::AVG_W-1:0]      rssi,
    input  logic [rota_pkg::HYST_W-1:0]            hyst,
    input  rota_pkg::entry_t                       cur,
    output rota_pkg::entry_t                       nxt,
    output rota_pkg::res_t                         res
);
    import rota_pkg::*;

    logic signed [AVG_W-1:0] a0;
    logic signed [AVG_W-1:0] a1;
    logic signed [AVG_W-1:0] a_sel;
    logic signed [AVG_W-1:0] a_new;
    logic signed [15:0]      s16;
    logic signed [15:0]      r16;
    logic signed [15:0]      acc;
    logic signed [15:0]      adj;
    logic signed [15:0]      quo;
    logic signed [13:0]      diff;
    logic signed [13:0]      h_pos;
    logic signed [13:0]      h_neg;
    owner_t                  own;

    always_comb begin
        a0    = cur.avg0;
        a1    = cur.avg1;
        a_sel = ant ? a1 : a0;

        // (avg*7 + rssi) / 8, truncating toward zero
        s16 = {{4{a_sel[AVG_W-1]}}, a_sel};
        r16 = {{4{rssi[AVG_W-1]}}, rssi};
        acc = (s16 <<< 3) - s16 + r16;
        adj = acc + (acc[15] ? 16'sd7 : 16'sd0);
        quo = adj >>> 3;
        a_new = cur.seen[ant] ? quo[AVG_W-1:0] : rssi;

        diff  = {{2{a0[AVG_W-1]}}, a0} - {{2{a1[AVG_W-1]}}, a1};
        h_pos = {4'b0000, hyst};
        h_neg = -h_pos;

        own = cur.owner;
        if (cur.seen == 2'b01) begin
            own = OWN_ANT0;
        end else if (cur.seen == 2'b10) begin
            own = OWN_ANT1;
        end else if (cur.owner == OWN_NONE) begin
            own = diff[13] ? OWN_ANT1 : OWN_ANT0;
        end else if (cur.owner == OWN_ANT0 && diff < h_neg) begin
            own = OWN_ANT1;
        end else if (cur.owner == OWN_ANT1 && diff > h_pos) begin
            own = OWN_ANT0;
        end

        nxt = cur;
        if (op == OP_UPDATE) begin
            nxt.seen[ant] = 1'b1;
            if (ant) begin
                nxt.avg1 = a_new;
            end else begin
                nxt.avg0 = a_new;
            end
        end else begin
            nxt.owner = own;
        end

        res.owner   = own;
        res.pass    = (own == OWN_NONE) || (own == {1'b0, ant} + 2'd1);
        res.tracked = 1'b1;
    end

endmodule

// File: sv/rssi_owner_arbiter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_owner_arbiter_table
// Dual-antenna RSSI owner arbiter over a table of 96-bit tag EPCs.
// ----------------------------------------------------------------------------
// One request is handled at a time. The EPC is searched linearly through the
// key RAM, one entry per cycle with the compare in the cycle after the read;
// a hit goes on to the data read, a miss appends the EPC while there is room,
// then the entry is modified and a decide waits in the output state for the
// result slot to drain before the next request is accepted.
// Update requests give no response; decide requests give one. A new EPC is
// appended while the table has room; on a full table an update is dropped and
// a decide answers owner 0, pass 1, tracked 0. The result register lets a
// request be accepted while the previous response is still waiting.
// Hysteresis may be written at any time the block is idle and applies to
// later decides.
// ----------------------------------------------------------------------------
module rssi_owner_arbiter_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] epc_high, [95:32] epc_low, [107:96] rssi, [111:108] zero
    input  logic [rota_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] opcode, [1] antenna
    input  logic [rota_pkg::S_USER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] owner, [2] pass, [3] tracked, [7:4] zero
    output logic [rota_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rota_pkg::HYST_W-1:0]       cfg_data
);
    import rota_pkg::*;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]       slot_reg, slot_next;
    logic                    hit_reg, hit_next;
    logic [HYST_W-1:0]       hyst_reg;
    op_t                     op_reg;
    logic                    ant_reg;
    logic [KEY_W-1:0]        key_reg;
    logic signed [AVG_W-1:0] rssi_reg;
    res_t                    res_reg, res_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    res_t                    m_res_reg, m_res_next;

    logic                    s_accept;
    logic                    issue;
    logic                    key_match;
    logic                    last_cmp;
    logic                    has_room;
    logic                    out_free;

    logic                    key_we;
    logic [ADDR_W-1:0]       key_waddr;
    logic [ADDR_W-1:0]       key_raddr;
    logic [KEY_W-1:0]        key_rdata;
    logic                    data_we;
    logic [ADDR_W-1:0]       data_raddr;
    logic [ENTRY_W-1:0]      data_rdata;
    entry_t                  cur_entry;
    entry_t                  nxt_entry;
    res_t                    calc_res;

    rota_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    rota_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (slot_reg),
        .wdata (nxt_entry),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    assign cur_entry = hit_reg ? entry_t'(data_rdata) : entry_t'('0);

    rota_calc u_calc (
        .op   (op_reg),
        .ant  (ant_reg),
        .rssi (rssi_reg),
        .hyst (hyst_reg),
        .cur  (cur_entry),
        .nxt  (nxt_entry),
        .res  (calc_res)
    );

    assign s_accept  = s_tvalid && s_tready;
    assign issue     = (state_reg == ST_SEARCH) && (idx_reg < count_reg);
    assign key_match = (key_rdata == key_reg);
    assign last_cmp  = ({1'b0, cmp_idx_reg} == count_reg - CNT_W'(1));
    assign has_room  = (count_reg < CNT_W'(TABLE_DEPTH));
    assign out_free  = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmp_vld_next = issue;
        cmp_idx_next = idx_reg[ADDR_W-1:0];
        slot_next    = slot_reg;
        hit_next     = hit_reg;
        res_next     = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = (count_reg == '0) ? ST_MISS : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (issue) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (cmp_vld_reg && key_match) begin
                    slot_next  = cmp_idx_reg;
                    hit_next   = 1'b1;
                    state_next = ST_DATA_RD;
                end else if (cmp_vld_reg && last_cmp) begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS: begin
                if (has_room) begin
                    slot_next  = count_reg[ADDR_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_MODIFY;
                end else if (op_reg == OP_DECIDE) begin
                    res_next   = '{tracked: 1'b0, pass: 1'b1, owner: OWN_NONE};
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DATA_RD: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                res_next   = calc_res;
                state_next = (op_reg == OP_DECIDE) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and RAM controls
    always_comb begin
        s_tready      = 1'b0;
        key_we        = 1'b0;
        data_we       = 1'b0;
        key_waddr     = count_reg[ADDR_W-1:0];
        key_raddr     = idx_reg[ADDR_W-1:0];
        data_raddr    = slot_reg;
        m_res_next    = m_res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_MISS:    key_we   = has_room;
            ST_MODIFY:  data_we  = 1'b1;
            ST_OUT: begin
                if (out_free) begin
                    m_res_next    = res_reg;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'b0000, m_res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            hyst_reg     <= HYST_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            hit_reg      <= hit_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                hyst_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        res_reg     <= res_next;
        m_res_reg   <= m_res_next;
        if (s_accept) begin
            op_reg   <= op_t'(s_tuser[0]);
            ant_reg  <= s_tuser[1];
            key_reg  <= s_tdata[KEY_W-1:0];
            rssi_reg <= s_tdata[KEY_W +: AVG_W];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_cmp_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH && cmp_vld_reg) |-> ({1'b0, cmp_idx_reg} < count_reg))
        else $error("compare beyond filled entries");

    a_out_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (op_reg == OP_DECIDE))
        else $error("response pending for an update request");

    a_write_after_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MODIFY) |-> ($past(state_reg) == ST_DATA_RD || $past(state_reg) == ST_MISS))
        else $error("entry written without lookup");

endmodule

// File: dv/rssi_owner_arbiter_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_owner_arbiter_table_checker
// Passive scoreboard for the RSSI owner arbiter table.
// ----------------------------------------------------------------------------
// Watches the request, response and hysteresis channels. Every accepted
// request is applied to a local copy of the EPC table (averages, seen flags,
// owners); decide requests queue the owner/pass/tracked response they must
// produce. Each accepted response is compared field by field against the
// oldest queued one. Counts go back to the testbench top.
// ----------------------------------------------------------------------------
module rssi_owner_arbiter_table_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rota_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [rota_pkg::S_USER_W-1:0]   s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rota_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rota_pkg::HYST_W-1:0]     cfg_data,
    output int                              mismatch_cnt,
    output int                              pending_cnt,
    output int                              decide_cnt,
    output int                              untracked_cnt,
    output int                              dropped_cnt,
    output int                              switch_cnt
);
    import rota_pkg::*;

    logic [KEY_HI_W-1:0] tag_hi     [TABLE_DEPTH];
    logic [KEY_LO_W-1:0] tag_lo     [TABLE_DEPTH];
    int                  avg_ant0   [TABLE_DEPTH];
    int                  avg_ant1   [TABLE_DEPTH];
    logic [1:0]          seen_mask  [TABLE_DEPTH];
    owner_t              owner_of   [TABLE_DEPTH];
    int                  tags_held  = 0;
    int                  hyst_now   = int'(HYST_RESET);
    res_t                owner_expect_q [$];

    int errs       = 0;
    int decides    = 0;
    int untracked  = 0;
    int dropped    = 0;
    int switches   = 0;

    // slot of the EPC, appended when new and there is room; -1 when full
    function automatic int lookup_tag(input logic [KEY_HI_W-1:0] hi,
                                      input logic [KEY_LO_W-1:0] lo);
        int i;
        for (i = 0; i < tags_held; i++) begin
            if (tag_hi[i] == hi && tag_lo[i] == lo)
                return i;
        end
        if (tags_held >= TABLE_DEPTH)
            return -1;
        i = tags_held;
        tags_held++;
        tag_hi[i]    = hi;
        tag_lo[i]    = lo;
        avg_ant0[i]  = 0;
        avg_ant1[i]  = 0;
        seen_mask[i] = 2'b00;
        owner_of[i]  = OWN_NONE;
        return i;
    endfunction

    task automatic track_request(input op_t op, input logic ant,
                                 input logic [KEY_HI_W-1:0] hi,
                                 input logic [KEY_LO_W-1:0] lo,
                                 input int rssi);
        int     slot;
        int     diff;
        owner_t own;
        res_t   r;
        slot = lookup_tag(hi, lo);
        if (op == OP_UPDATE) begin
            if (slot < 0) begin
                dropped++;
                return;
            end
            if (ant)
                avg_ant1[slot] = seen_mask[slot][1] ? (avg_ant1[slot] * 7 + rssi) / 8 : rssi;
            else
                avg_ant0[slot] = seen_mask[slot][0] ? (avg_ant0[slot] * 7 + rssi) / 8 : rssi;
            seen_mask[slot][ant] = 1'b1;
            return;
        end
        decides++;
        if (slot < 0) begin
            untracked++;
            r.owner   = OWN_NONE;
            r.pass    = 1'b1;
            r.tracked = 1'b0;
        end else begin
            diff = avg_ant0[slot] - avg_ant1[slot];
            own  = owner_of[slot];
            case (seen_mask[slot])
                2'b01: own = OWN_ANT0;
                2'b10: own = OWN_ANT1;
                default: begin
                    if (own == OWN_NONE) begin
                        own = (diff >= 0) ? OWN_ANT0 : OWN_ANT1;
                    end else if (own == OWN_ANT0 && diff < -hyst_now) begin
                        own = OWN_ANT1;
                        switches++;
                    end else if (own == OWN_ANT1 && diff > hyst_now) begin
                        own = OWN_ANT0;
                        switches++;
                    end
                end
            endcase
            owner_of[slot] = own;
            r.owner   = own;
            r.pass    = (own == OWN_NONE) || (own == (ant ? OWN_ANT1 : OWN_ANT0));
            r.tracked = 1'b1;
        end
        owner_expect_q.push_back(r);
    endtask

    task automatic check_response(input res_t got);
        res_t want;
        if (owner_expect_q.size() == 0) begin
            $error("unexpected response 0x%0h with no decide request pending", got);
            errs++;
            return;
        end
        want = owner_expect_q.pop_front();
        if (got.owner !== want.owner) begin
            $error("owner: expected %0d, got %0d", want.owner, got.owner);
            errs++;
        end
        if (got.pass !== want.pass) begin
            $error("pass: expected %0d, got %0d", want.pass, got.pass);
            errs++;
        end
        if (got.tracked !== want.tracked) begin
            $error("tracked: expected %0d, got %0d", want.tracked, got.tracked);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tags_held = 0;
            hyst_now  = int'(HYST_RESET);
            owner_expect_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                hyst_now = int'(cfg_data);
            if (s_tvalid && s_tready)
                track_request(op_t'(s_tuser[0]), s_tuser[1], s_tdata[31:0],
                              s_tdata[95:32], $signed(s_tdata[107:96]));
            if (m_tvalid && m_tready)
                check_response(res_t'(m_tdata[3:0]));
        end
        mismatch_cnt  <= errs;
        pending_cnt   <= owner_expect_q.size();
        decide_cnt    <= decides;
        untracked_cnt <= untracked;
        dropped_cnt   <= dropped;
        switch_cnt    <= switches;
    end

endmodule

// File: dv/rssi_owner_arbiter_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_owner_arbiter_table_tb
// Stimulus and verdict for the RSSI owner arbiter table.
// ----------------------------------------------------------------------------
// A directed opening walks first sightings, min/max RSSI, truncating averages,
// undecided/one-sided/both-sided decides and near-miss EPCs. Random phases then
// run under several hysteresis settings, mostly on the EPCs the table holds,
// with fresh EPCs that fill the table and then hit the full-table paths. Both
// sides idle at random; one phase has no idling and one holds the response
// side off long enough to back up the request side.
// ----------------------------------------------------------------------------
module rssi_owner_arbiter_table_tb;
    import rota_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 60;
    localparam int PHASE_REQS   = 150;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [S_USER_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [HYST_W-1:0]    cfg_data  = '0;

    int mismatch_cnt, pending_cnt, decide_cnt, untracked_cnt, dropped_cnt, switch_cnt;

    bit jitter_on  = 1'b0;
    bit hold_go    = 1'b0;
    int stall_left = 0;
    int cycles     = 0;
    int req_sent   = 0;

    logic [KEY_HI_W-1:0] tag_pool_hi [$];
    logic [KEY_LO_W-1:0] tag_pool_lo [$];

    rssi_owner_arbiter_table i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rssi_owner_arbiter_table_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatch_cnt  (mismatch_cnt),
        .pending_cnt   (pending_cnt),
        .decide_cnt    (decide_cnt),
        .untracked_cnt (untracked_cnt),
        .dropped_cnt   (dropped_cnt),
        .switch_cnt    (switch_cnt)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, pending_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // response side: random backpressure plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_go)
            stall_left <= HOLD_CYCLES;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        if (hold_go || stall_left > 1)
            m_tready <= 1'b0;
        else if (jitter_on)
            m_tready <= ($urandom_range(99) >= 35);
        else
            m_tready <= 1'b1;
    end

    // EPCs the table should end up holding: the first TABLE_DEPTH distinct ones
    function automatic void remember_tag(input logic [KEY_HI_W-1:0] hi,
                                         input logic [KEY_LO_W-1:0] lo);
        int i;
        for (i = 0; i < tag_pool_hi.size(); i++) begin
            if (tag_pool_hi[i] == hi && tag_pool_lo[i] == lo)
                return;
        end
        if (tag_pool_hi.size() < TABLE_DEPTH) begin
            tag_pool_hi.push_back(hi);
            tag_pool_lo.push_back(lo);
        end
    endfunction

    task automatic send_req(input op_t op, input logic ant,
                            input logic [KEY_HI_W-1:0] hi,
                            input logic [KEY_LO_W-1:0] lo,
                            input logic [AVG_W-1:0] rssi);
        s_tvalid <= 1'b1;
        s_tuser  <= {ant, op};
        s_tdata  <= {4'b0000, rssi, lo, hi};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        remember_tag(hi, lo);
        req_sent++;
        if (jitter_on && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic random_req();
        int                  pick;
        int                  fresh_pct;
        int                  k;
        int                  level;
        logic [KEY_W-1:0]    key;
        logic [KEY_HI_W-1:0] hi;
        logic [KEY_LO_W-1:0] lo;
        logic [AVG_W-1:0]    rssi;
        fresh_pct = (tag_pool_hi.size() >= TABLE_DEPTH) ? 8 : 25;
        pick = $urandom_range(99);
        if (tag_pool_hi.size() == 0 || pick < fresh_pct / 2) begin
            hi = $urandom;
            lo = {$urandom, $urandom};
        end else begin
            k   = $urandom_range(tag_pool_hi.size() - 1);
            key = {tag_pool_hi[k], tag_pool_lo[k]};
            if (pick < fresh_pct)
                key = key ^ (96'd1 << $urandom_range(KEY_W - 1));
            hi = key[KEY_W-1:KEY_LO_W];
            lo = key[KEY_LO_W-1:0];
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
            level = -700 + int'($urandom_range(400));
            rssi  = level[AVG_W-1:0];
        end else if (pick < 85) begin
            rssi = AVG_W'($urandom);
        end else if (pick < 92) begin
            rssi = 12'h7FF;
        end else begin
            rssi = 12'h800;
        end
        send_req(($urandom_range(99) < 35) ? OP_DECIDE : OP_UPDATE,
                 1'($urandom_range(1)), hi, lo, rssi);
    endtask

    // stop offering, let every response land, then let the block go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_hyst(input logic [HYST_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [KEY_HI_W-1:0] a_hi, b_hi, c_hi, e_hi;
        logic [KEY_LO_W-1:0] a_lo, b_lo, c_lo, d_lo, e_lo;
        int                  hyst_plan [6];
        int                  p;

        a_hi = 32'h3015_A2C7;
        a_lo = 64'h9E44_0B1D_5F62_C8E3;
        b_hi = '1;
        b_lo = '1;
        c_hi = '0;
        c_lo = '0;
        d_lo = a_lo ^ 64'd1;
        e_hi = b_hi ^ 32'h8000_0000;
        e_lo = b_lo;
        hyst_plan = '{0, 1023, 1, 1022, 15, 30};
        hyst_plan[4] = $urandom_range(2, 1021);

        repeat (12) @(posedge aclk);
        aresetn   <= 1'b1;
        jitter_on <= 1'b1;
        @(posedge aclk);

        // directed opening at reset hysteresis
        send_req(OP_DECIDE, 1'b1, a_hi, a_lo, 12'h000);   // new tag, nothing seen
        send_req(OP_UPDATE, 1'b1, a_hi, a_lo, 12'h7FF);
        send_req(OP_DECIDE, 1'b0, a_hi, a_lo, 12'h000);   // only antenna 1 seen
        send_req(OP_UPDATE, 1'b0, a_hi, a_lo, 12'h800);
        send_req(OP_UPDATE, 1'b0, a_hi, a_lo, 12'h800);
        send_req(OP_DECIDE, 1'b1, a_hi, a_lo, 12'h000);
        send_req(OP_UPDATE, 1'b0, b_hi, b_lo, 12'(100));
        send_req(OP_UPDATE, 1'b1, b_hi, b_lo, 12'(50));
        send_req(OP_DECIDE, 1'b0, b_hi, b_lo, 12'h7FF);   // both seen, undecided
        send_req(OP_UPDATE, 1'b1, b_hi, b_lo, 12'h7FF);
        send_req(OP_DECIDE, 1'b0, b_hi, b_lo, 12'h800);   // gap beyond hysteresis
        send_req(OP_UPDATE, 1'b0, c_hi, c_lo, 12'(-5));
        send_req(OP_UPDATE, 1'b1, c_hi, c_lo, 12'(-5));
        send_req(OP_DECIDE, 1'b1, c_hi, c_lo, 12'h000);   // equal averages
        send_req(OP_UPDATE, 1'b0, c_hi, c_lo, 12'(-4));   // truncates toward zero
        send_req(OP_UPDATE, 1'b1, a_hi, d_lo, 12'(-300)); // one bit off tag A
        send_req(OP_DECIDE, 1'b1, a_hi, d_lo, 12'h000);
        send_req(OP_UPDATE, 1'b0, e_hi, e_lo, 12'h000);
        send_req(OP_DECIDE, 1'b0, e_hi, e_lo, 12'h000);
        send_req(OP_DECIDE, 1'b0, c_hi, c_lo, 12'h000);
        send_req(OP_UPDATE, 1'b1, a_hi, a_lo, 12'hFFF);
        send_req(OP_DECIDE, 1'b0, a_hi, a_lo, 12'h000);

        for (p = 0; p < 6; p++) begin
            drain();
            write_hyst(HYST_W'(hyst_plan[p]));
            jitter_on <= (p != 1);
            if (p == 2) begin
                hold_go <= 1'b1;
                @(posedge aclk);
                hold_go <= 1'b0;
            end
            repeat (PHASE_REQS) random_req();
        end
        drain();

        $display("%0d requests sent, %0d decides checked (%0d untracked), %0d updates dropped",
                 req_sent, decide_cnt, untracked_cnt, dropped_cnt);
        $display("hysteresis swept 30,0,1023,1,1022,%0d,30; %0d owner switches", hyst_plan[4],
                 switch_cnt);
        if (mismatch_cnt == 0 && pending_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
